// File: hdl/bedc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bedc_pkg
// Shared constants, register indexes and saturation helpers of the boost energy
// duty controller.
// ----------------------------------------------------------------------------
package bedc_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned DUTY_W  = 16;
    localparam int unsigned CFG_IW  = 3;
    localparam int unsigned OP_W    = 33;
    localparam int unsigned PROD_W  = 66;
    localparam int unsigned DVD_W   = 64;
    localparam int unsigned IN_W    = 160;
    localparam int unsigned OUT_W   = 144;

    localparam logic [DUTY_W-1:0] DUTY_MAX  = 16'd64225;
    localparam logic [15:0]       ALPHA_RST = 16'd655;

    // Register indexes
    localparam logic [CFG_IW-1:0] REG_IND   = 3'd0;
    localparam logic [CFG_IW-1:0] REG_CAP   = 3'd1;
    localparam logic [CFG_IW-1:0] REG_K1    = 3'd2;
    localparam logic [CFG_IW-1:0] REG_K2    = 3'd3;
    localparam logic [CFG_IW-1:0] REG_ALPHA = 3'd4;

    // Saturate a signed 64-bit value to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Saturate an unsigned 64-bit energy sum to 0x7FFFFFFF
    function automatic logic [31:0] satu31(input logic [63:0] x);
        logic [31:0] r;
        if (x > 64'h0000_0000_7FFF_FFFF) begin
            r = 32'h7FFF_FFFF;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage : bedc_pkg
`default_nettype wire

// File: hdl/bedc_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bedc_mul
// Shared signed 33 x 33 multiplier with a registered product.
// ----------------------------------------------------------------------------
module bedc_mul
    import bedc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic signed [OP_W-1:0]   i_a,
    input  wire logic signed [OP_W-1:0]   i_b,
    output logic signed [PROD_W-1:0]      o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    // Product register
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule : bedc_mul
`default_nettype wire

// File: hdl/bedc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bedc_div
// Unsigned restoring divider, 64-bit dividend by 32-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module bedc_div
    import bedc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [DVD_W-1:0]   i_dividend,
    input  wire logic [DATA_W-1:0]  i_divisor,
    output logic                    o_done,
    output logic [DVD_W-1:0]        o_quotient
);

    logic [DVD_W-1:0]  r_quo;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_dvs;
    logic [5:0]        r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DATA_W:0]   w_trial;
    logic [DATA_W:0]   w_diff;
    logic              w_bit;

    // Shift-subtract step
    always_comb begin
        w_trial = {r_rem, r_quo[DVD_W-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        w_bit   = (w_trial >= {1'b0, r_dvs});
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], w_bit};
            r_rem <= w_bit ? w_diff[DATA_W-1:0] : w_trial[DATA_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule : bedc_div
`default_nettype wire

// File: hdl/boost_energy_duty_controller_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// boost_energy_duty_controller_unit
// Energy-based boost converter duty controller on one shared multiplier and
// one shared divider.
// ----------------------------------------------------------------------------
// One sample is taken at a time: s_axis_tready is high only while the block
// is idle. A sample without fault runs three divisions on the shared
// divider: the reference current, the duty numerator and the duty itself.
// The last division is skipped when the numerator falls outside 0..vo. A
// fault skips the duty setup states S_R1 to S_R5 and both duty divisions;
// when the input voltage is not positive the reference current division is
// skipped too. Each division runs the 64-step restoring divider, and each
// product passes through the multiplier's product register. The result
// then waits in the output register until m_axis_tready takes it.
module boost_energy_duty_controller_unit
    import bedc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // configuration write port
    input  wire logic                i_cfg_wr_en,
    input  wire logic [CFG_IW-1:0]   i_cfg_index,
    input  wire logic [DATA_W-1:0]   i_cfg_data,
    // input stream
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // tdata from bit 0: inductor_current, load_current, input_voltage,
    // output_voltage, voltage_setpoint (32 bits each)
    input  wire logic [IN_W-1:0]     s_axis_tdata,
    // output stream
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // tdata from bit 0: duty_cycle (16), setpoint_echo, stored_energy,
    // reference_energy, filtered_current (32 each)
    output logic [OUT_W-1:0]         m_axis_tdata,
    // tuser: division_fault
    output logic                     m_axis_tuser
);

    // Sequencer codes
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_F1   = 5'd1;
    localparam logic [4:0] S_F2   = 5'd2;
    localparam logic [4:0] S_F3   = 5'd3;
    localparam logic [4:0] S_D1   = 5'd4;
    localparam logic [4:0] S_D2   = 5'd5;
    localparam logic [4:0] S_D3   = 5'd6;
    localparam logic [4:0] S_ESQ  = 5'd7;
    localparam logic [4:0] S_EHI  = 5'd8;
    localparam logic [4:0] S_ELO  = 5'd9;
    localparam logic [4:0] S_EAC  = 5'd10;
    localparam logic [4:0] S_I1   = 5'd11;
    localparam logic [4:0] S_I2   = 5'd12;
    localparam logic [4:0] S_I3   = 5'd13;
    localparam logic [4:0] S_R1   = 5'd14;
    localparam logic [4:0] S_R2   = 5'd15;
    localparam logic [4:0] S_R3   = 5'd16;
    localparam logic [4:0] S_R4   = 5'd17;
    localparam logic [4:0] S_R5   = 5'd18;
    localparam logic [4:0] S_R6   = 5'd19;
    localparam logic [4:0] S_R7   = 5'd20;
    localparam logic [4:0] S_OUT  = 5'd21;

    // Configuration registers
    logic [31:0]        r_ind, r_cap;
    logic signed [31:0] r_k1, r_k2;
    logic [15:0]        r_alpha;

    // Sample and working registers
    logic [4:0]         r_state;
    logic signed [31:0] r_il, r_io, r_vi, r_vo, r_vr;
    logic signed [31:0] r_avg, r_edot, r_iref, r_rho;
    logic [31:0]        r_e, r_eref;
    logic signed [63:0] r_acc;
    logic [63:0]        r_mid, r_esum;
    logic [31:0]        r_lo;
    logic [1:0]         r_term;
    logic               r_neg;
    logic               r_fault;
    logic [DUTY_W-1:0]  r_duty;

    // Shared units
    logic signed [OP_W-1:0]   w_ma, w_mb;
    logic signed [PROD_W-1:0] w_prod;
    logic                     w_dstart;
    logic [DVD_W-1:0]         w_dvd;
    logic [DATA_W-1:0]        w_dvs;
    logic                     w_ddone;
    logic [DVD_W-1:0]         w_quo;

    // Helpers
    logic signed [31:0] w_ex;
    logic [31:0]        w_ek;
    logic signed [63:0] w_p64;
    logic signed [63:0] w_sh16;
    logic signed [63:0] w_rl;
    logic signed [63:0] w_sq;
    logic signed [63:0] w_num;
    logic signed [63:0] w_facc;
    logic [63:0]        w_term;
    logic [63:0]        w_esum;

    bedc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .o_prod (w_prod)
    );

    bedc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_dstart),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_ddone),
        .o_quotient (w_quo)
    );

    // Energy term operands: (il,L) (vo,C) (iref,L) (vr,C)
    always_comb begin
        case (r_term)
            2'd0:    begin w_ex = r_il;   w_ek = r_ind; end
            2'd1:    begin w_ex = r_vo;   w_ek = r_cap; end
            2'd2:    begin w_ex = r_iref; w_ek = r_ind; end
            default: begin w_ex = r_vr;   w_ek = r_cap; end
        endcase
    end

    // Derived values from the product register and the divider quotient
    always_comb begin
        w_p64  = w_prod[63:0];
        w_sh16 = 64'(w_prod >>> 16);
        w_rl   = w_sh16;
        w_facc = r_acc + w_p64 + 64'sd32768;
        w_term = (r_mid + {32'b0, w_prod[63:32]}) >> 9;
        w_esum = r_esum + w_term;
        w_sq   = r_neg ? -$signed(w_quo) : $signed(w_quo);
        w_num  = w_sq + 64'(r_vo) - 64'(r_vi);
    end

    // Multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_F1:  begin w_ma = {17'b0, r_alpha};  w_mb = 33'(r_io); end
            S_F2:  begin w_ma = 33'(17'h10000 - {1'b0, r_alpha}); w_mb = 33'(r_avg); end
            S_D1:  begin w_ma = 33'(r_il);  w_mb = 33'(r_vi); end
            S_D2:  begin w_ma = 33'(r_avg); w_mb = 33'(r_vo); end
            S_ESQ: begin w_ma = 33'(w_ex);  w_mb = 33'(w_ex); end
            S_EHI: begin w_ma = {1'b0, w_prod[63:32]}; w_mb = {1'b0, w_ek}; end
            S_ELO: begin w_ma = {1'b0, r_lo}; w_mb = {1'b0, w_ek}; end
            S_I1:  begin w_ma = 33'(r_avg); w_mb = 33'(r_vr); end
            S_R1:  begin
                w_ma = $signed({1'b0, r_eref}) - $signed({1'b0, r_e});
                w_mb = 33'(r_k1);
            end
            S_R2:  begin w_ma = 33'(r_edot); w_mb = 33'(r_k2); end
            S_R4:  begin w_ma = 33'(r_rho);  w_mb = {1'b0, r_ind}; end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    // Divider start and operands
    always_comb begin
        w_dstart = 1'b0;
        w_dvd    = '0;
        w_dvs    = r_vi;
        case (r_state)
            S_I2: begin
                w_dstart = (r_vi > 0);
                w_dvd    = w_p64[63] ? 64'(-w_p64) : w_p64;
            end
            S_R5: begin
                w_dstart = 1'b1;
                w_dvd    = w_rl[63] ? 64'(-w_rl) : w_rl;
            end
            S_R6: begin
                w_dstart = w_ddone && (w_num > 0) && (w_num < 64'(r_vo));
                w_dvd    = 64'(w_num <<< 16);
                w_dvs    = r_vo;
            end
            default: begin
                w_dstart = 1'b0;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ind   <= '0;
            r_cap   <= '0;
            r_k1    <= '0;
            r_k2    <= '0;
            r_alpha <= ALPHA_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_IND:   r_ind   <= i_cfg_data;
                REG_CAP:   r_cap   <= i_cfg_data;
                REG_K1:    r_k1    <= i_cfg_data;
                REG_K2:    r_k2    <= i_cfg_data;
                REG_ALPHA: r_alpha <= i_cfg_data[15:0];
                default:   ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_avg   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_il    <= s_axis_tdata[31:0];
                        r_io    <= s_axis_tdata[63:32];
                        r_vi    <= s_axis_tdata[95:64];
                        r_vo    <= s_axis_tdata[127:96];
                        r_vr    <= s_axis_tdata[159:128];
                        r_fault <= ($signed(s_axis_tdata[95:64]) <= 0) ||
                                   ($signed(s_axis_tdata[127:96]) <= 0);
                        r_duty  <= '0;
                        r_state <= S_F1;
                    end
                end
                S_F1: r_state <= S_F2;
                S_F2: begin
                    r_acc   <= w_p64;
                    r_state <= S_F3;
                end
                S_F3: begin
                    r_avg   <= sat32(w_facc >>> 16);
                    r_state <= S_D1;
                end
                S_D1: r_state <= S_D2;
                S_D2: begin
                    r_acc   <= w_sh16;
                    r_state <= S_D3;
                end
                S_D3: begin
                    r_edot  <= sat32(r_acc - w_sh16);
                    r_term  <= 2'd0;
                    r_esum  <= '0;
                    r_state <= S_ESQ;
                end
                // energy term: square, high and low partial products, sum
                S_ESQ: r_state <= S_EHI;
                S_EHI: begin
                    r_lo    <= w_prod[31:0];
                    r_state <= S_ELO;
                end
                S_ELO: begin
                    r_mid   <= w_p64;
                    r_state <= S_EAC;
                end
                S_EAC: begin
                    r_term <= r_term + 2'd1;
                    unique case (r_term)
                        2'd0, 2'd2: begin
                            r_esum  <= w_esum;
                            r_state <= S_ESQ;
                        end
                        2'd1: begin
                            r_e     <= satu31(w_esum);
                            r_esum  <= '0;
                            r_state <= S_I1;
                        end
                        default: begin
                            r_eref  <= satu31(w_esum);
                            r_state <= r_fault ? S_OUT : S_R1;
                        end
                    endcase
                end
                // reference current
                S_I1: r_state <= S_I2;
                S_I2: begin
                    r_neg <= w_p64[63];
                    if (r_vi > 0) begin
                        r_state <= S_I3;
                    end else begin
                        r_iref  <= '0;
                        r_state <= S_ESQ;
                    end
                end
                S_I3: begin
                    if (w_ddone) begin
                        r_iref  <= sat32(w_sq);
                        r_state <= S_ESQ;
                    end
                end
                // duty path
                S_R1: r_state <= S_R2;
                S_R2: begin
                    r_acc   <= 64'(w_prod >>> 24);
                    r_state <= S_R3;
                end
                S_R3: begin
                    r_rho   <= sat32(r_acc - w_sh16);
                    r_state <= S_R4;
                end
                S_R4: r_state <= S_R5;
                S_R5: begin
                    r_neg   <= w_rl[63];
                    r_state <= S_R6;
                end
                S_R6: begin
                    if (w_ddone) begin
                        if (w_num <= 0) begin
                            r_duty  <= '0;
                            r_state <= S_OUT;
                        end else if (w_num >= 64'(r_vo)) begin
                            r_duty  <= DUTY_MAX;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_R7;
                        end
                    end
                end
                S_R7: begin
                    if (w_ddone) begin
                        r_duty  <= (w_quo > 64'(DUTY_MAX)) ? DUTY_MAX : w_quo[15:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Stream ports
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {r_avg, r_eref, r_e, r_vr, r_duty};
    assign m_axis_tuser  = r_fault;

endmodule : boost_energy_duty_controller_unit
`default_nettype wire
